FILE: rtl/dthc_pkg.sv
// ----------------------------------------------------------------------------
// dthc_pkg: shared types and constants of the depth to hue colorizer
// Field types, clamp limits, sector codes and the ramp arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package dthc_pkg;

    typedef logic [15:0] depth_t;
    typedef logic [7:0]  chan_t;
    typedef logic [13:0] span_t;
    typedef logic [11:0] rem_t;
    typedef logic [2:0]  sector_t;

    localparam depth_t DEPTH_NEAR_MM = 16'd400;
    localparam depth_t DEPTH_FAR_MM  = 16'd10000;
    localparam span_t  FAR_SPAN      = 14'd10000;
    localparam span_t  NEAR_SPAN     = 14'd400;
    localparam span_t  SECTOR_SPAN   = 14'd2400;
    localparam chan_t  FULL_CHANNEL  = 8'd255;
    localparam chan_t  ZERO_CHANNEL  = 8'd0;

    localparam sector_t SECTOR_RED_YELLOW   = 3'd0;
    localparam sector_t SECTOR_YELLOW_GREEN = 3'd1;
    localparam sector_t SECTOR_GREEN_CYAN   = 3'd2;
    localparam sector_t SECTOR_CYAN_BLUE    = 3'd3;
    localparam sector_t SECTOR_BLUE_MAGENTA = 3'd4;

    // 255 / 2400 equals 17 / 160. The division by 5 uses the reciprocal
    // 13108 / 65536, which is exact for quotients below 1276.
    localparam logic [15:0] RAMP_MUL  = 16'd17;
    localparam logic [13:0] FIFTH_MUL = 14'd13108;

    function automatic chan_t ramp_of(input rem_t part, input logic full);
        logic [15:0] prod17;
        logic [10:0] quot32;
        logic [24:0] prod5;
        begin
            prod17 = {3'b000, full, part} * RAMP_MUL;
            quot32 = prod17[15:5];
            prod5  = {14'd0, quot32} * {11'd0, FIFTH_MUL};
            ramp_of = prod5[23:16];
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dthc_depth_if.sv
// ----------------------------------------------------------------------------
// dthc_depth_if: depth sample channel
// Valid/ready channel that carries one depth sample in millimeters.
// ----------------------------------------------------------------------------
`default_nettype none

interface dthc_depth_if import dthc_pkg::*;;
    logic   valid;
    logic   ready;
    depth_t depth_mm;

    modport source (output valid, output depth_mm, input ready);
    modport sink   (input valid, input depth_mm, output ready);
endinterface

`default_nettype wire

FILE: rtl/dthc_pixel_if.sv
// ----------------------------------------------------------------------------
// dthc_pixel_if: RGBA pixel channel
// Valid/ready channel that carries one colorized RGBA pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface dthc_pixel_if import dthc_pkg::*;;
    logic  valid;
    logic  ready;
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/depth_to_hue_color.sv
// ----------------------------------------------------------------------------
// depth_to_hue_color: depth sample to RGBA hue colorizer
// Maps each depth sample onto a hue ramp from blue (near) to red (far); a zero depth gives black.
// ----------------------------------------------------------------------------
//  Channel | Direction | Interface     | Payload
//  depth   | in        | dthc_depth_if | depth_mm
//  pixel   | out       | dthc_pixel_if | red, green, blue, alpha
//
//  An item passes an input register and a result register, with the hue logic
//  between them, and its pixel is valid from the result register.
//  One item is accepted in every cycle while the pixel side takes items.
//  A stalled pixel holds; the input register keeps accepting until both
//  registers are full. Reset empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_to_hue_color import dthc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dthc_depth_if.sink  depth,
    dthc_pixel_if.source pixel
);

    logic    in_valid_reg;
    depth_t  depth_reg;
    logic    out_valid_reg;
    chan_t   red_reg;
    chan_t   green_reg;
    chan_t   blue_reg;

    logic    advance;
    logic    in_take;
    span_t   clamped;
    span_t   hue_u;
    span_t   sector_base;
    sector_t sector;
    rem_t    rem;
    chan_t   up;
    chan_t   down;
    chan_t   red_next;
    chan_t   green_next;
    chan_t   blue_next;

    assign advance     = !out_valid_reg || pixel.ready;
    assign depth.ready = !in_valid_reg || advance;
    assign in_take     = depth.valid && depth.ready;

    always_comb
    begin
        if (depth_reg > DEPTH_FAR_MM)
        begin
            clamped = FAR_SPAN;
        end
        else if (depth_reg < DEPTH_NEAR_MM)
        begin
            clamped = NEAR_SPAN;
        end
        else
        begin
            clamped = depth_reg[13:0];
        end
        hue_u = FAR_SPAN - clamped;

        if (hue_u >= 14'(4 * 2400))
        begin
            sector      = SECTOR_BLUE_MAGENTA;
            sector_base = 14'(4 * 2400);
        end
        else if (hue_u >= 14'(3 * 2400))
        begin
            sector      = SECTOR_CYAN_BLUE;
            sector_base = 14'(3 * 2400);
        end
        else if (hue_u >= 14'(2 * 2400))
        begin
            sector      = SECTOR_GREEN_CYAN;
            sector_base = 14'(2 * 2400);
        end
        else if (hue_u >= SECTOR_SPAN)
        begin
            sector      = SECTOR_YELLOW_GREEN;
            sector_base = SECTOR_SPAN;
        end
        else
        begin
            sector      = SECTOR_RED_YELLOW;
            sector_base = 14'd0;
        end
        rem = 12'(hue_u - sector_base);
    end

    span_t down_span;
    assign down_span = SECTOR_SPAN - {2'b00, rem};
    assign up        = ramp_of(rem, 1'b0);
    assign down      = ramp_of(down_span[11:0], down_span[12]);

    always_comb
    begin
        case (sector)
            SECTOR_RED_YELLOW:
            begin
                red_next = FULL_CHANNEL; green_next = up;           blue_next = ZERO_CHANNEL;
            end
            SECTOR_YELLOW_GREEN:
            begin
                red_next = down;         green_next = FULL_CHANNEL; blue_next = ZERO_CHANNEL;
            end
            SECTOR_GREEN_CYAN:
            begin
                red_next = ZERO_CHANNEL; green_next = FULL_CHANNEL; blue_next = up;
            end
            SECTOR_CYAN_BLUE:
            begin
                red_next = ZERO_CHANNEL; green_next = down;         blue_next = FULL_CHANNEL;
            end
            SECTOR_BLUE_MAGENTA:
            begin
                red_next = up;           green_next = ZERO_CHANNEL; blue_next = FULL_CHANNEL;
            end
            default:
            begin
                red_next = FULL_CHANNEL; green_next = ZERO_CHANNEL; blue_next = down;
            end
        endcase
        if (depth_reg == '0)
        begin
            red_next   = ZERO_CHANNEL;
            green_next = ZERO_CHANNEL;
            blue_next  = ZERO_CHANNEL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (depth.ready)
            begin
                in_valid_reg <= depth.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            depth_reg <= depth.depth_mm;
        end
        if (advance && in_valid_reg)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign pixel.valid = out_valid_reg;
    assign pixel.red   = red_reg;
    assign pixel.green = green_reg;
    assign pixel.blue  = blue_reg;
    assign pixel.alpha = FULL_CHANNEL;

endmodule

`default_nettype wire

FILE: rtl/dthc_checker.sv
// ----------------------------------------------------------------------------
// dthc_checker: port-level checks of the depth to hue colorizer
// Watches the depth and pixel channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dthc_checker import dthc_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  in_ready,
    input wire logic  out_valid,
    input wire logic  out_ready,
    input wire chan_t red,
    input wire chan_t green,
    input wire chan_t blue,
    input wire chan_t alpha
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("pixel valid during reset");

    // The input side only stalls when both registers hold items.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a stalled pixel");

    a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (alpha == FULL_CHANNEL))
        else $error("alpha is not opaque");

    // A full-saturation hue always has one channel at full scale, unless black.
    a_pure_hue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red == FULL_CHANNEL || green == FULL_CHANNEL ||
                       blue == FULL_CHANNEL ||
                       (red == ZERO_CHANNEL && green == ZERO_CHANNEL &&
                        blue == ZERO_CHANNEL)))
        else $error("pixel is not a pure hue");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(red) && $stable(green) && $stable(blue)))
        else $error("stalled pixel changed");

endmodule

bind depth_to_hue_color dthc_checker u_dthc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (depth.ready),
    .out_valid (pixel.valid),
    .out_ready (pixel.ready),
    .red       (pixel.red),
    .green     (pixel.green),
    .blue      (pixel.blue),
    .alpha     (pixel.alpha)
);

`default_nettype wire

FILE: tb/tb_depth_to_hue_color.sv
// ----------------------------------------------------------------------------
// tb_depth_to_hue_color: self-checking testbench of the depth colorizer
// Streams depth samples through the block with random bursts and output
// stalls. Each pixel is checked against a hue ramp computed here in exact
// integer form.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_depth_to_hue_color;
    import dthc_pkg::*;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
    } pixel_t;

    localparam int RANDOM_ITEMS = 1630;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 150;
    localparam int REPORT_MAX   = 10;

    logic clk;
    logic rst_n;

    dthc_depth_if depth_ch ();
    dthc_pixel_if pixel_ch ();

    depth_to_hue_color uut (
        .clk   (clk),
        .rst_n (rst_n),
        .depth (depth_ch),
        .pixel (pixel_ch)
    );

    depth_t pending_depths[$];
    pixel_t expected_pixels[$];

    int depths_sent;
    int mismatches;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int stall_mode;
    int mode_cycles;
    int hold_left;
    logic hold_off;
    logic hold_done;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic pixel_t colorize(depth_t d);
        int unsigned clamped;
        int unsigned offset;
        int unsigned rem;
        int unsigned up;
        int unsigned down;
        pixel_t p;
        begin
            p = '{red: ZERO_CHANNEL, green: ZERO_CHANNEL, blue: ZERO_CHANNEL,
                  alpha: FULL_CHANNEL};
            if (d != 0)
            begin
                clamped = d;
                if (clamped > DEPTH_FAR_MM)
                    clamped = DEPTH_FAR_MM;
                if (clamped < DEPTH_NEAR_MM)
                    clamped = DEPTH_NEAR_MM;
                offset = DEPTH_FAR_MM - clamped;
                rem  = offset % SECTOR_SPAN;
                up   = rem * FULL_CHANNEL / SECTOR_SPAN;
                down = (SECTOR_SPAN - rem) * FULL_CHANNEL / SECTOR_SPAN;
                case (sector_t'(offset / SECTOR_SPAN))
                    SECTOR_RED_YELLOW:
                    begin
                        p.red = FULL_CHANNEL;
                        p.green = chan_t'(up);
                    end
                    SECTOR_YELLOW_GREEN:
                    begin
                        p.red = chan_t'(down);
                        p.green = FULL_CHANNEL;
                    end
                    SECTOR_GREEN_CYAN:
                    begin
                        p.green = FULL_CHANNEL;
                        p.blue = chan_t'(up);
                    end
                    SECTOR_CYAN_BLUE:
                    begin
                        p.green = chan_t'(down);
                        p.blue = FULL_CHANNEL;
                    end
                    SECTOR_BLUE_MAGENTA:
                    begin
                        p.red = chan_t'(up);
                        p.blue = FULL_CHANNEL;
                    end
                    default:
                    begin
                        p.red = FULL_CHANNEL;
                        p.blue = chan_t'(down);
                    end
                endcase
            end
            colorize = p;
        end
    endfunction

    function automatic depth_t random_depth();
        int sel;
        int base;
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: random_depth = '0;
                1: random_depth = depth_t'($urandom_range(1, 399));
                2: random_depth = depth_t'($urandom_range(10001, 65535));
                3:
                begin
                    base = 400 + 2400 * $urandom_range(0, 4);
                    random_depth = depth_t'(base + $urandom_range(0, 4) - 2);
                end
                4: random_depth = depth_t'($urandom());
                default: random_depth = depth_t'($urandom_range(400, 10000));
            endcase
        end
    endfunction

    // Driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_ch.valid <= 1'b0;
            depth_ch.depth_mm <= '0;
            burst_left = 0;
            gap_left = 0;
            depths_sent <= 0;
        end
        else
        begin
            if (depth_ch.valid && depth_ch.ready)
            begin
                expected_pixels.push_back(colorize(depth_ch.depth_mm));
                depths_sent <= depths_sent + 1;
            end
            if (!depth_ch.valid || depth_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    depth_ch.valid <= 1'b0;
                end
                else if (pending_depths.size() > 0)
                begin
                    depth_ch.valid <= 1'b1;
                    depth_ch.depth_mm <= pending_depths.pop_front();
                    if (burst_left > 0)
                        burst_left = burst_left - 1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                begin
                    depth_ch.valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off of the receiver while the sender keeps offering.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off <= 1'b0;
            hold_done <= 1'b0;
            hold_left <= 0;
        end
        else if (!hold_done && !hold_off && depths_sent >= 300)
        begin
            hold_off <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_off)
        begin
            if (hold_left <= 1)
            begin
                hold_off <= 1'b0;
                hold_done <= 1'b1;
            end
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: a stall pattern is drawn each time the mode counter wraps, results checked in order.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t exp_pix;
        logic next_ready;
        if (!rst_n)
        begin
            pixel_ch.ready <= 1'b0;
            stall_mode <= 0;
            mode_cycles <= 0;
        end
        else
        begin
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    if (mismatches < REPORT_MAX)
                        $display("unexpected pixel r=%0d g=%0d b=%0d a=%0d",
                                 pixel_ch.red, pixel_ch.green, pixel_ch.blue,
                                 pixel_ch.alpha);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_pix = expected_pixels.pop_front();
                    if (pixel_ch.red !== exp_pix.red || pixel_ch.green !== exp_pix.green ||
                        pixel_ch.blue !== exp_pix.blue || pixel_ch.alpha !== exp_pix.alpha)
                    begin
                        if (mismatches < REPORT_MAX)
                            $display("pixel mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     exp_pix.red, exp_pix.green, exp_pix.blue, exp_pix.alpha,
                                     pixel_ch.red, pixel_ch.green, pixel_ch.blue,
                                     pixel_ch.alpha);
                        mismatches <= mismatches + 1;
                    end
                end
            end

            case (stall_mode)
                0: next_ready = 1'b1;
                1: next_ready = $urandom_range(0, 1);
                2: next_ready = ($urandom_range(0, 9) != 0);
                3: next_ready = (mode_cycles % 4 != 3);
                default: next_ready = (mode_cycles % 16 < 10);
            endcase
            if (hold_off)
                next_ready = 1'b0;
            pixel_ch.ready <= next_ready;

            if (mode_cycles == 63)
            begin
                mode_cycles <= 0;
                stall_mode <= $urandom_range(0, 4);
            end
            else
            begin
                mode_cycles <= mode_cycles + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((depth_ch.valid && depth_ch.ready) || (pixel_ch.valid && pixel_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("depth_to_hue_color test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;

        pending_depths = '{16'd0, 16'd1, 16'd399, 16'd400, 16'd401, 16'd2799, 16'd2800,
                           16'd2801, 16'd5199, 16'd5200, 16'd5201, 16'd7599, 16'd7600,
                           16'd7601, 16'd9999, 16'd10000, 16'd10001, 16'd32768,
                           16'd65535, 16'd21845, 16'd43690, 16'd6000};
        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_depths.push_back(random_depth());

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_depths.size() != 0 || depth_ch.valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("depth_to_hue_color test passed");
        else
            $display("depth_to_hue_color test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/dthc_pkg.sv
rtl/dthc_depth_if.sv
rtl/dthc_pixel_if.sv
rtl/depth_to_hue_color.sv
rtl/dthc_checker.sv
tb/tb_depth_to_hue_color.sv
